### src/artr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// artr_pkg
// Shared types, constants and helpers for the acknowledge-retaining
// transmit ring: ring geometry, item layouts and the mode codes.
// ----------------------------------------------------------------------------
package artr_pkg;

    // ring geometry
    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // field widths
    localparam int MODE_W  = 2;
    localparam int STAMP_W = 32;
    localparam int BODY_W  = 64;
    localparam int ENTRY_W = STAMP_W + BODY_W;

    // item modes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEND = 2'd2;

    // input item
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [STAMP_W-1:0] stamp;
        logic [BODY_W-1:0]  payload;
        logic               link_ready;
    } t_in_item;

    // result item
    typedef struct packed {
        logic               sent_valid;
        logic [STAMP_W-1:0] sent_stamp;
        logic [BODY_W-1:0]  sent_payload;
        logic               ack_ok;
        logic               dropped;
        logic [CNT_W-1:0]   occupancy;
        logic               is_empty;
        logic               is_full;
    } t_out_item;

    // advance a ring pointer with wrap
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### src/artr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// artr_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module artr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic                                        i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### src/artr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// artr_ctrl
// Ring pointers, counts and item sequencer. Issues the packet store access
// on the accept cycle and updates after the read, once the output is free.
// ----------------------------------------------------------------------------
module artr_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire artr_pkg::t_in_item          i_in_item,
    input  wire logic                        i_res_free,
    output logic                             o_res_valid,
    output artr_pkg::t_out_item              o_res_item,
    output logic                             o_wr_en,
    output logic [artr_pkg::PTR_W-1:0]       o_wr_addr,
    output logic [artr_pkg::ENTRY_W-1:0]     o_wr_data,
    output logic                             o_rd_en,
    output logic [artr_pkg::PTR_W-1:0]       o_rd_addr,
    input  wire logic [artr_pkg::ENTRY_W-1:0] i_rd_data
);
    import artr_pkg::*;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state           r_state;
    t_in_item         r_item;
    logic [PTR_W-1:0] r_oldest_ptr, n_oldest_ptr;
    logic [PTR_W-1:0] r_send_ptr,   n_send_ptr;
    logic [PTR_W-1:0] r_write_ptr,  n_write_ptr;
    logic [CNT_W-1:0] r_held,       n_held;
    logic [CNT_W-1:0] r_inflight,   n_inflight;
    logic             w_accept;
    logic             w_finish;
    logic [STAMP_W-1:0] w_rd_stamp;
    logic [BODY_W-1:0]  w_rd_body;
    t_out_item        w_res;

    // one item at a time: accept only when idle
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_finish   = (r_state == S_EXEC) && i_res_free;

    // store access on the accept cycle
    assign o_wr_en   = w_accept && (i_in_item.mode == MODE_PUSH);
    assign o_wr_addr = r_write_ptr;
    assign o_wr_data = {i_in_item.stamp, i_in_item.payload};
    assign o_rd_en   = w_accept;
    assign o_rd_addr = (i_in_item.mode == MODE_ACK) ? r_oldest_ptr : r_send_ptr;

    assign w_rd_stamp = i_rd_data[ENTRY_W-1 -: STAMP_W];
    assign w_rd_body  = i_rd_data[BODY_W-1:0];

    // pointer and count update, result composition
    always_comb begin
        n_oldest_ptr = r_oldest_ptr;
        n_send_ptr   = r_send_ptr;
        n_write_ptr  = r_write_ptr;
        n_held       = r_held;
        n_inflight   = r_inflight;
        w_res        = '0;
        case (r_item.mode)
            MODE_PUSH: begin
                if (r_held == CNT_W'(RING_DEPTH)) begin
                    w_res.dropped = 1'b1;
                    if (r_inflight == '0) begin
                        n_send_ptr = ring_next(r_send_ptr);
                    end else begin
                        n_inflight = r_inflight - CNT_W'(1);
                    end
                    n_oldest_ptr = ring_next(r_oldest_ptr);
                end else begin
                    n_held = r_held + CNT_W'(1);
                end
                n_write_ptr = ring_next(r_write_ptr);
            end
            MODE_ACK: begin
                if ((r_held != '0) && (w_rd_stamp == r_item.stamp)) begin
                    w_res.ack_ok = 1'b1;
                    if (r_inflight != '0) begin
                        n_inflight = r_inflight - CNT_W'(1);
                    end else begin
                        n_send_ptr = ring_next(r_send_ptr);
                    end
                    n_oldest_ptr = ring_next(r_oldest_ptr);
                    n_held       = r_held - CNT_W'(1);
                end
            end
            MODE_SEND: begin
                if (r_item.link_ready && (r_held > r_inflight)) begin
                    w_res.sent_valid   = 1'b1;
                    w_res.sent_stamp   = w_rd_stamp;
                    w_res.sent_payload = w_rd_body;
                    n_send_ptr         = ring_next(r_send_ptr);
                    n_inflight         = r_inflight + CNT_W'(1);
                end
            end
            default: begin
                // unused mode: status only
            end
        endcase
        w_res.occupancy = n_held;
        w_res.is_empty  = (n_held == '0);
        w_res.is_full   = (n_held == CNT_W'(RING_DEPTH));
    end

    assign o_res_valid = w_finish;
    assign o_res_item  = w_res;

    // sequencer and ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_oldest_ptr <= '0;
            r_send_ptr   <= '0;
            r_write_ptr  <= '0;
            r_held       <= '0;
            r_inflight   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_finish) begin
                        r_state      <= S_IDLE;
                        r_oldest_ptr <= n_oldest_ptr;
                        r_send_ptr   <= n_send_ptr;
                        r_write_ptr  <= n_write_ptr;
                        r_held       <= n_held;
                        r_inflight   <= n_inflight;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_accept) begin
            r_item <= i_in_item;
        end
    end

endmodule
`default_nettype wire

### src/ack_retained_transmit_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ack_retained_transmit_ring
// Transmit ring that keeps timestamped packets until they are acknowledged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one command
//   per transfer: push a packet, acknowledge the oldest packet by timestamp,
//   or offer a send opportunity to the link.
//   Output channel (o_out_valid / i_out_stall / o_out_item) returns exactly
//   one result per command: the emitted packet if any, ack and drop flags,
//   and occupancy, empty and full after the command.
//   Sequencing: an accepted command first reads the packet store through its
//   registered read port; once the output register is free, its result is
//   registered there and pointers and counts are updated. A new command is
//   accepted only after the previous one has finished, since the read data
//   must return before pointers and counts are updated.
//   Reset clears pointers and counts; the packet store keeps its contents and
//   needs no clearing pass, since data read from entries not held is unused.
//   When the receiver stalls, the finished result waits in the output
//   register; one more command is accepted and then held in the sequencer
//   until the output register drains.
// ----------------------------------------------------------------------------
module ack_retained_transmit_ring (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire artr_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output artr_pkg::t_out_item       o_out_item
);
    import artr_pkg::*;

    logic               w_wr_en;
    logic [PTR_W-1:0]   w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic               w_rd_en;
    logic [PTR_W-1:0]   w_rd_addr;
    logic [ENTRY_W-1:0] w_rd_data;
    logic               w_res_free;
    logic               w_res_valid;
    t_out_item          w_res_item;
    logic               r_out_valid;
    t_out_item          r_out_item;

    // packet store: stamp and body side by side
    artr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // pointers, counts and sequencing
    artr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_res_free  (w_res_free),
        .o_res_valid (w_res_valid),
        .o_res_item  (w_res_item),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    // output register is free when empty or being drained this cycle
    assign w_res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_out_item <= w_res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

### src/artr_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// artr_check
// Port-level checks for the transmit ring, attached to the top level.
// ----------------------------------------------------------------------------
module artr_check (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 o_in_stall,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire artr_pkg::t_out_item  o_out_item
);
    import artr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // one command in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second command taken while one is in work");

    // empty flag agrees with occupancy
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.is_empty == (o_out_item.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    // full flag agrees with occupancy, which never exceeds the ring depth
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.occupancy <= CNT_W'(RING_DEPTH)) &&
            (o_out_item.is_full == (o_out_item.occupancy == CNT_W'(RING_DEPTH))))
        else $error("full flag or occupancy out of range");

    // a command does at most one of send, ack and drop
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_out_item.sent_valid, o_out_item.ack_ok,
            o_out_item.dropped}) <= 1)
        else $error("more than one event in a result");

endmodule

bind ack_retained_transmit_ring artr_check u_artr_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire
